// ----- rtl/rbsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbsc_pkg
// Shared constants, types and helpers of the RSA block stream cipher.
// ----------------------------------------------------------------------------
package rbsc_pkg;

  localparam int MOD_BITS    = 31;
  localparam int W_W         = $clog2(MOD_BITS + 1);  // block width 1..MOD_BITS
  localparam int IDX_W       = $clog2(MOD_BITS);      // bit index into a residue
  localparam int BYTE_BITS   = 8;
  localparam int BYTE_CNT_W  = $clog2(BYTE_BITS + 1);
  localparam int PEND_W      = BYTE_BITS - 1;
  localparam int PCNT_W      = $clog2(BYTE_BITS);
  localparam int QDEPTH      = 16;
  localparam int QIDX_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int MAX_OUT     = 6;
  localparam int REL_W       = $clog2(MAX_OUT + 1);
  localparam int MM_W        = MOD_BITS + 2;          // 2r + a stays below 3n
  localparam int CFG_IDX_W   = 1;

  localparam logic [BYTE_BITS-1:0] TOP_BIT_OF_BYTE = 8'h80;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODULUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_POW,
    ST_EMIT,
    ST_TAIL,
    ST_FLUSH,
    ST_REL
  } st_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_REDUCE,
    EX_TEST,
    EX_MRES,
    EX_SHIFT,
    EX_MSQR,
    EX_DONE
  } ex_state_t;

  typedef struct packed {
    logic                start;
    logic [MOD_BITS-1:0] a;
    logic [MOD_BITS-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic                done;
    logic [MOD_BITS-1:0] p;
  } mm_rsp_t;

  typedef struct packed {
    logic                start;
    logic [MOD_BITS-1:0] v;
  } ex_req_t;

  typedef struct packed {
    logic                done;
    logic [MOD_BITS-1:0] res;
  } ex_rsp_t;

  typedef struct packed {
    logic                 push;
    logic [BYTE_BITS-1:0] byte_val;
    logic                 mark;
    logic                 release_en;
  } q_cmd_t;

  // bit length of v: position of the highest set bit plus one
  function automatic logic [W_W-1:0] bit_len(input logic [MOD_BITS-1:0] v);
    logic [W_W-1:0] len;
    len = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      if (v[i]) begin
        len = W_W'(i + 1);
      end
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rbsc_modmul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbsc_modmul
// Shared modular multiplier: a * b mod n, one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
module rbsc_modmul
  import rbsc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mm_req_t             req,
  input  wire logic [MOD_BITS-1:0] n,
  input  wire logic [W_W-1:0]      w,
  output      mm_rsp_t             rsp
);

  logic                busy_r;
  logic                done_r;
  logic [MOD_BITS-1:0] a_r;
  logic [MOD_BITS-1:0] b_r;
  logic [MOD_BITS-1:0] acc_r;
  logic [IDX_W-1:0]    idx_r;

  logic [MM_W-1:0]     sum2;
  logic [MM_W-1:0]     n1;
  logic [MM_W-1:0]     n2;
  logic [MOD_BITS-1:0] acc_nxt;

  // 2r + bit*a < 3n, so at most two subtractions of n
  always_comb begin
    n1   = MM_W'(n);
    n2   = n1 << 1;
    sum2 = (MM_W'(acc_r) << 1) + (b_r[idx_r] ? MM_W'(a_r) : '0);
    if (sum2 >= n2) begin
      acc_nxt = MOD_BITS'(sum2 - n2);
    end else if (sum2 >= n1) begin
      acc_nxt = MOD_BITS'(sum2 - n1);
    end else begin
      acc_nxt = MOD_BITS'(sum2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && idx_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
      idx_r <= IDX_W'(w - W_W'(1));
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      idx_r <= idx_r - IDX_W'(1);
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule
`default_nettype wire

// ----- rtl/rbsc_expo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbsc_expo
// Square-and-multiply sequencer, exponent LSB first, on the shared multiplier.
// ----------------------------------------------------------------------------
module rbsc_expo
  import rbsc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ex_req_t             req,
  input  wire logic [MOD_BITS-1:0] e,
  input  wire logic [MOD_BITS-1:0] n,
  output      ex_rsp_t             rsp,
  output      mm_req_t             mm_req,
  input  wire mm_rsp_t             mm_rsp
);

  ex_state_t           st_r, st_nxt;
  logic [MOD_BITS-1:0] x_r, x_nxt;
  logic [MOD_BITS-1:0] e_r, e_nxt;
  logic [MOD_BITS-1:0] res_r, res_nxt;
  logic [MOD_BITS-1:0] e_shr;

  assign e_shr = e_r >> 1;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      EX_IDLE:   if (req.start) st_nxt = EX_REDUCE;
      EX_REDUCE: st_nxt = EX_TEST;
      EX_TEST: begin
        if (x_r == '0 || e_r == '0) begin
          st_nxt = EX_DONE;
        end else if (e_r[0]) begin
          st_nxt = EX_MRES;
        end else begin
          st_nxt = EX_SHIFT;
        end
      end
      EX_MRES:   if (mm_rsp.done) st_nxt = EX_SHIFT;
      EX_SHIFT:  st_nxt = (e_shr == '0) ? EX_DONE : EX_MSQR;
      EX_MSQR:   if (mm_rsp.done) st_nxt = EX_TEST;
      EX_DONE:   st_nxt = EX_IDLE;
      default:   st_nxt = EX_IDLE;
    endcase
  end

  always_comb begin
    x_nxt        = x_r;
    e_nxt        = e_r;
    res_nxt      = res_r;
    mm_req.start = 1'b0;
    mm_req.a     = res_r;
    mm_req.b     = x_r;
    case (st_r)
      EX_IDLE: begin
        if (req.start) begin
          x_nxt = req.v;
          e_nxt = e;
        end
      end
      EX_REDUCE: begin
        // block value is below 2^w < 2n
        if (x_r >= n) x_nxt = x_r - n;
        res_nxt = MOD_BITS'(1);
      end
      EX_TEST: begin
        // a zero base gives zero, whatever the exponent
        if (x_r == '0) begin
          res_nxt = '0;
        end else if (e_r != '0 && e_r[0]) begin
          mm_req.start = 1'b1;
        end
      end
      EX_MRES: begin
        if (mm_rsp.done) res_nxt = mm_rsp.p;
      end
      EX_SHIFT: begin
        e_nxt = e_shr;
        if (e_shr != '0) begin
          mm_req.start = 1'b1;
          mm_req.a     = x_r;
        end
      end
      EX_MSQR: begin
        if (mm_rsp.done) x_nxt = mm_rsp.p;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= EX_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    e_r   <= e_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = (st_r == EX_DONE);
  assign rsp.res  = res_r;

endmodule
`default_nettype wire

// ----- rtl/rbsc_outq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbsc_outq
// Output byte queue with last flags, release gating and output register.
// ----------------------------------------------------------------------------
module rbsc_outq
  import rbsc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire q_cmd_t               cmd,
  output      logic                 rel_empty,
  output      logic                 out_tvalid,
  input  wire logic                 out_tready,
  output      logic [BYTE_BITS-1:0] out_tdata,
  output      logic                 out_tlast
);

  logic [BYTE_BITS-1:0] q_byte_r [QDEPTH];
  logic                 q_last_r [QDEPTH];

  logic [QIDX_W-1:0]    hd_r;
  logic [REL_W-1:0]     rel_r;    // words released, still in the ring
  logic [QCNT_W-1:0]    cnt_r;    // words queued, not yet released
  logic                 ovalid_r;
  logic [BYTE_BITS-1:0] obyte_r;
  logic                 olast_r;

  logic [QIDX_W-1:0]    tail;
  logic [QIDX_W-1:0]    newest;
  logic [REL_W-1:0]     rel_amt;
  logic                 pop;
  logic                 do_push;

  assign tail    = hd_r + QIDX_W'(rel_r) + QIDX_W'(cnt_r);
  assign newest  = tail - QIDX_W'(1);
  assign rel_amt = (cnt_r > QCNT_W'(MAX_OUT)) ? REL_W'(MAX_OUT) : REL_W'(cnt_r);
  assign pop     = (rel_r != '0) && (!ovalid_r || out_tready);
  // a word that finds the queue full is dropped
  assign do_push = cmd.push && (cnt_r < QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_r     <= '0;
      rel_r    <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (pop) hd_r <= hd_r + QIDX_W'(1);
      rel_r <= rel_r + (cmd.release_en ? rel_amt : '0) - (pop ? REL_W'(1) : '0);
      cnt_r <= cnt_r + (do_push ? QCNT_W'(1) : '0)
                     - (cmd.release_en ? QCNT_W'(rel_amt) : '0);
      if (pop) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_byte_r[tail] <= cmd.byte_val;
      q_last_r[tail] <= 1'b0;
    end
    if (cmd.mark && cnt_r != '0) begin
      q_last_r[newest] <= 1'b1;
    end
    if (pop) begin
      obyte_r <= q_byte_r[hd_r];
      olast_r <= q_last_r[hd_r];
    end
  end

  assign rel_empty  = (rel_r == '0);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

// ----- rtl/rsa_block_stream_cipher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_block_stream_cipher
// Byte stream in, w-bit blocks raised to the key exponent mod n, bytes out.
// ----------------------------------------------------------------------------
// Each input word carries one message byte (MSB first) and a last flag. Bits
// are gathered into blocks of w = bitlen(n - 1) bits; every full block becomes
// (v mod n)^e mod n and its w bits are repacked MSB first into output words.
// On a last word the partial block and partial output byte are zero-padded and
// the final word goes out with out_tlast. After a byte is accepted the block
// stays busy while it finishes its blocks; each block needs up to
// popcount(e) + bitlen(e) - 1 products of the shared bit-serial modular
// multiplier (none for a zero base or a zero exponent), and a last word adds
// the zero padding. in_tready is high only between bytes, once every released
// word has left the queue, at one word per cycle while out_tready is high;
// up to six queued words are released per byte, a queue of 16 holds the
// rest, and a word finding it full is dropped. The user must write registers
// with cfg_wr_en only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rsa_block_stream_cipher
  import rbsc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // in_tdata: [7:0] data_byte
  input  wire logic                 in_tvalid,
  output      logic                 in_tready,
  input  wire logic [BYTE_BITS-1:0] in_tdata,
  input  wire logic                 in_tlast,   // last_byte
  // out_tdata: [7:0] out_byte
  output      logic                 out_tvalid,
  input  wire logic                 out_tready,
  output      logic [BYTE_BITS-1:0] out_tdata,
  output      logic                 out_tlast,  // out_last
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MOD_BITS-1:0]  cfg_wdata
);

  st_t                   st_r, st_nxt;
  logic [MOD_BITS-1:0]   key_exp_r;
  logic [MOD_BITS-1:0]   key_mod_r;
  logic [MOD_BITS-1:0]   n_r, n_nxt;
  logic [W_W-1:0]        w_r, w_nxt;
  logic [BYTE_BITS-1:0]  data_r, data_nxt;
  logic                  last_r, last_nxt;
  logic [BYTE_CNT_W-1:0] left_r, left_nxt;
  logic [MOD_BITS-1:0]   block_r, block_nxt;
  logic [W_W-1:0]        fill_r, fill_nxt;
  logic [IDX_W-1:0]      emit_r, emit_nxt;
  logic [PEND_W-1:0]     pend_r, pend_nxt;
  logic [PCNT_W-1:0]     pcnt_r, pcnt_nxt;

  logic [MOD_BITS-1:0]   n_eff;
  logic                  accept;
  logic                  bit_in;
  logic [MOD_BITS-1:0]   blk_shift;
  logic [MOD_BITS-1:0]   blk_pad;
  logic [W_W-1:0]        fill_inc;
  logic [MOD_BITS-1:0]   wmask;
  logic                  obit_vld;
  logic                  obit;

  ex_req_t ex_req;
  ex_rsp_t ex_rsp;
  mm_req_t mm_req;
  mm_rsp_t mm_rsp;
  q_cmd_t  q_cmd;
  logic    rel_empty;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_exp_r <= MOD_BITS'(1);
      key_mod_r <= MOD_BITS'(2);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY_EXPONENT: key_exp_r <= cfg_wdata;
        CFG_KEY_MODULUS:  key_mod_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign n_eff = (key_mod_r < MOD_BITS'(2)) ? MOD_BITS'(2) : key_mod_r;

  // ---- datapath helpers ----
  assign accept    = in_tvalid && in_tready;
  assign bit_in    = |(data_r & TOP_BIT_OF_BYTE);
  assign blk_shift = {block_r[MOD_BITS-2:0], bit_in};
  assign fill_inc  = fill_r + W_W'(1);
  assign wmask     = ~({MOD_BITS{1'b1}} << w_r);
  assign blk_pad   = block_r << (w_r - fill_r);

  // ---- sequencer: next state ----
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_BIT;
      ST_BIT: begin
        if (fill_inc >= w_r) begin
          st_nxt = ST_POW;
        end else if (left_r == BYTE_CNT_W'(1)) begin
          st_nxt = ST_TAIL;
        end
      end
      ST_POW:  if (ex_rsp.done) st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_r == '0) st_nxt = (left_r != '0) ? ST_BIT : ST_TAIL;
      end
      ST_TAIL: begin
        if (!last_r) begin
          st_nxt = ST_REL;
        end else if (fill_r != '0) begin
          st_nxt = ST_POW;
        end else begin
          st_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: if (pcnt_r == '0) st_nxt = ST_REL;
      ST_REL:   st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs, datapath and output bit packer ----
  always_comb begin
    in_tready        = 1'b0;
    n_nxt            = n_r;
    w_nxt            = w_r;
    data_nxt         = data_r;
    last_nxt         = last_r;
    left_nxt         = left_r;
    block_nxt        = block_r;
    fill_nxt         = fill_r;
    emit_nxt         = emit_r;
    ex_req.start     = 1'b0;
    ex_req.v         = blk_shift & wmask;
    obit_vld         = 1'b0;
    obit             = 1'b0;
    q_cmd.mark       = 1'b0;
    q_cmd.release_en = 1'b0;
    pend_nxt         = pend_r;
    pcnt_nxt         = pcnt_r;
    q_cmd.push       = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_tready = rel_empty;
        if (accept) begin
          data_nxt = in_tdata;
          last_nxt = in_tlast;
          left_nxt = BYTE_CNT_W'(BYTE_BITS);
          n_nxt    = n_eff;
          w_nxt    = bit_len(n_eff - MOD_BITS'(1));
        end
      end
      ST_BIT: begin
        data_nxt = data_r << 1;
        left_nxt = left_r - BYTE_CNT_W'(1);
        // fill can already be past w after a modulus change
        if (fill_inc >= w_r) begin
          ex_req.start = 1'b1;
          block_nxt    = '0;
          fill_nxt     = '0;
        end else begin
          block_nxt = blk_shift;
          fill_nxt  = fill_inc;
        end
      end
      ST_POW: begin
        if (ex_rsp.done) emit_nxt = IDX_W'(w_r - W_W'(1));
      end
      ST_EMIT: begin
        obit_vld = 1'b1;
        obit     = ex_rsp.res[emit_r];
        emit_nxt = emit_r - IDX_W'(1);
      end
      ST_TAIL: begin
        if (last_r && fill_r != '0) begin
          ex_req.start = 1'b1;
          ex_req.v     = blk_pad & wmask;
          block_nxt    = '0;
          fill_nxt     = '0;
        end
      end
      ST_FLUSH: begin
        if (pcnt_r != '0) begin
          obit_vld = 1'b1;
        end else begin
          q_cmd.mark = 1'b1;
        end
      end
      ST_REL: q_cmd.release_en = 1'b1;
      default: ;
    endcase
    // output bit packer
    q_cmd.byte_val = {pend_r, obit};
    if (obit_vld) begin
      pend_nxt   = {pend_r[PEND_W-2:0], obit};
      pcnt_nxt   = pcnt_r + PCNT_W'(1);
      q_cmd.push = (pcnt_r == PCNT_W'(BYTE_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      block_r <= '0;
      fill_r  <= '0;
      pend_r  <= '0;
      pcnt_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      block_r <= block_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    w_r    <= w_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
    left_r <= left_nxt;
    emit_r <= emit_nxt;
  end

  // ---- units ----
  rbsc_expo u_expo (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ex_req),
    .e      (key_exp_r),
    .n      (n_r),
    .rsp    (ex_rsp),
    .mm_req (mm_req),
    .mm_rsp (mm_rsp)
  );

  rbsc_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .n     (n_r),
    .w     (w_r),
    .rsp   (mm_rsp)
  );

  rbsc_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (q_cmd),
    .rel_empty  (rel_empty),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ----- sim/rsa_block_stream_cipher_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_block_stream_cipher_checker
// Watches the key writes and both stream channels of the cipher. Every
// accepted input word is run through a bit-accurate model of the block
// (gather, modular exponentiation, repack, release of up to six words), and
// every accepted output word is compared with the oldest predicted word.
// ----------------------------------------------------------------------------
module rsa_block_stream_cipher_checker
  import rbsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [BYTE_BITS-1:0] in_tdata,
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [BYTE_BITS-1:0] out_tdata,
  input  logic                 out_tlast,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MOD_BITS-1:0]  cfg_wdata,
  output int                   fail_count,
  output int                   pending_words
);

  typedef struct packed {
    logic [BYTE_BITS-1:0] byte_val;
    logic                 is_last;
  } out_word_t;

  out_word_t expected_bytes[$];

  logic [MOD_BITS-1:0]  key_exp;
  logic [MOD_BITS-1:0]  key_mod;
  logic [MOD_BITS-1:0]  blk_bits;
  int unsigned          blk_fill;
  logic [BYTE_BITS-1:0] pend_bits;
  int unsigned          pend_cnt;
  logic [BYTE_BITS-1:0] fifo_byte [QDEPTH];
  logic                 fifo_last [QDEPTH];
  int unsigned          fifo_head;
  int unsigned          fifo_cnt;
  int                   errors;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic longint unsigned modulus_in_use();
    return (key_mod < 2) ? 64'd2 : longint'(key_mod);
  endfunction

  // bit length of n - 1
  function automatic int unsigned block_width();
    longint unsigned v;
    int unsigned     w;
    v = modulus_in_use() - 1;
    w = 0;
    while (v != 0) begin
      w++;
      v = v >> 1;
    end
    return w;
  endfunction

  function automatic longint unsigned mod_mult(input longint unsigned a,
                                               input longint unsigned b,
                                               input longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      r = r << 1;
      if (r >= n) r = r - n;
      if (((b >> i) & 64'd1) != 0) begin
        r = r + a;
        if (r >= n) r = r - n;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned mod_power(input longint unsigned v,
                                                input longint unsigned e,
                                                input longint unsigned n);
    longint unsigned x;
    longint unsigned acc;
    x = v % n;
    acc = 1;
    if (x == 0) return 0;
    while (e != 0) begin
      if ((e & 64'd1) != 0) acc = mod_mult(acc, x, n);
      e = e >> 1;
      x = mod_mult(x, x, n);
    end
    return acc;
  endfunction

  task automatic queue_finished(input logic [BYTE_BITS-1:0] b);
    int unsigned pos;
    // a full queue drops the word
    if (fifo_cnt < QDEPTH) begin
      pos = (fifo_head + fifo_cnt) % QDEPTH;
      fifo_byte[pos] = b;
      fifo_last[pos] = 1'b0;
      fifo_cnt++;
    end
  endtask

  task automatic shift_out_bit(input logic b);
    pend_bits = {pend_bits[BYTE_BITS-2:0], b};
    pend_cnt++;
    if (pend_cnt >= BYTE_BITS) begin
      queue_finished(pend_bits);
      pend_bits = '0;
      pend_cnt = 0;
    end
  endtask

  task automatic close_block(input int unsigned w);
    longint unsigned v;
    longint unsigned r;
    v = blk_bits;
    v = v & ((64'd1 << w) - 64'd1);
    r = mod_power(v, longint'(key_exp), modulus_in_use());
    for (int i = int'(w) - 1; i >= 0; i--) begin
      shift_out_bit(((r >> i) & 64'd1) != 0);
    end
    blk_bits = '0;
    blk_fill = 0;
  endtask

  task automatic encrypt_byte(input logic [BYTE_BITS-1:0] data, input logic last_flag);
    int unsigned w;
    int          released;
    out_word_t   ew;
    w = block_width();
    for (int j = 0; j < BYTE_BITS; j++) begin
      blk_bits = {blk_bits[MOD_BITS-2:0], data[BYTE_BITS-1-j]};
      blk_fill++;
      // after a modulus change the fill may already be past the new width
      if (blk_fill >= w) close_block(w);
    end
    if (last_flag) begin
      if (blk_fill > 0) begin
        blk_bits = blk_bits << (w - blk_fill);
        close_block(w);
      end
      while (pend_cnt > 0) shift_out_bit(1'b0);
      if (fifo_cnt > 0) fifo_last[(fifo_head + fifo_cnt - 1) % QDEPTH] = 1'b1;
    end
    released = 0;
    while (fifo_cnt > 0 && released < MAX_OUT) begin
      ew.byte_val = fifo_byte[fifo_head];
      ew.is_last = fifo_last[fifo_head];
      expected_bytes.insert(expected_bytes.size(), ew);
      fifo_head = (fifo_head + 1) % QDEPTH;
      fifo_cnt--;
      released++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t ew;
    if (!rst_n) begin
      key_exp = 1;
      key_mod = 2;
      blk_bits = '0;
      blk_fill = 0;
      pend_bits = '0;
      pend_cnt = 0;
      fifo_head = 0;
      fifo_cnt = 0;
      for (int i = 0; i < QDEPTH; i++) begin
        fifo_byte[i] = '0;
        fifo_last[i] = 1'b0;
      end
      expected_bytes.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_KEY_EXPONENT) key_exp = cfg_wdata;
        else if (cfg_index == CFG_KEY_MODULUS) key_mod = cfg_wdata;
      end
      if (in_tvalid && in_tready) encrypt_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected word data=%02h last=%0b",
                                    out_tdata, out_tlast));
        end else begin
          ew = expected_bytes.pop_front();
          if (out_tdata !== ew.byte_val) begin
            report_mismatch($sformatf("data %02h, expected %02h", out_tdata, ew.byte_val));
          end
          if (out_tlast !== ew.is_last) begin
            report_mismatch($sformatf("last %0b, expected %0b (data %02h)",
                                      out_tlast, ew.is_last, ew.byte_val));
          end
        end
      end
    end
    fail_count <= errors;
    pending_words <= expected_bytes.size();
  end

endmodule

// ----- sim/rsa_block_stream_cipher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_block_stream_cipher_tb
// Drives message bytes and key writes into the cipher with random gaps on
// both stream sides; the checker predicts and compares every output word.
// A directed part covers key extremes, degenerate moduli, zero-congruent
// blocks, a modulus change in the middle of a block and a burst on the last
// byte; random phases with fresh keys and random messages follow.
// ----------------------------------------------------------------------------
module rsa_block_stream_cipher_tb
  import rbsc_pkg::*;
();

  localparam int RANDOM_WORDS = 400;
  // longest byte: two 31-bit blocks of 61 products each, plus padding
  localparam int DRAIN_CYCLES = 4500;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [BYTE_BITS-1:0] in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [BYTE_BITS-1:0] out_tdata;
  logic                 out_tlast;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MOD_BITS-1:0]  cfg_wdata = '0;
  int                   fail_count;
  int                   pending_words;
  int                   in_calm_left = 0;
  int                   out_calm_left = 0;

  rsa_block_stream_cipher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  rsa_block_stream_cipher_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  // gap before the next word; calm stretches have none
  function automatic int pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic drive_word(input logic [BYTE_BITS-1:0] data, input logic last_flag);
    int gap;
    gap = pick_gap(in_calm_left > 0);
    if (in_calm_left > 0) in_calm_left--;
    else if ($urandom_range(0, 9) == 0) in_calm_left = $urandom_range(4, 24);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tlast <= last_flag;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // stop sending, wait for every predicted word, then let the block go idle
  task automatic settle();
    @(negedge clk) in_tvalid <= 1'b0;
    wait (pending_words == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MOD_BITS-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  task automatic set_key(input logic [MOD_BITS-1:0] e, input logic [MOD_BITS-1:0] n);
    settle();
    write_reg(CFG_KEY_EXPONENT, e);
    write_reg(CFG_KEY_MODULUS, n);
  endtask

  // receiver: random stalls between words
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = pick_gap(out_calm_left > 0);
      if (out_calm_left > 0) out_calm_left--;
      else if ($urandom_range(0, 9) == 0) out_calm_left = $urandom_range(4, 24);
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  initial begin
    int                   sent;
    int                   msg_left;
    int                   phase_len;
    int                   sh;
    logic [MOD_BITS-1:0]  e;
    logic [MOD_BITS-1:0]  n;
    logic [BYTE_BITS-1:0] data;
    logic                 last_flag;

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset key: e = 1, n = 2, one-bit identity blocks
    drive_word(8'h00, 1'b0);
    drive_word(8'hFF, 1'b0);
    drive_word(8'hA5, 1'b1);

    // modulus 0 acts as 2; zero exponent still maps a zero block to 0
    set_key('0, '0);
    drive_word(8'h5A, 1'b0);
    drive_word(8'hFF, 1'b1);

    // modulus 1 acts as 2
    set_key('1, 31'd1);
    drive_word(8'h3C, 1'b1);

    // widest blocks; the first all-ones block equals n and gives 0
    set_key('1, '1);
    drive_word(8'hFF, 1'b0);
    drive_word(8'hFF, 1'b0);
    drive_word(8'hFF, 1'b0);
    drive_word(8'hFF, 1'b1);
    drive_word(8'h00, 1'b0);
    drive_word(8'h80, 1'b0);
    drive_word(8'h01, 1'b1);

    // 24 bits gathered at w = 31, then w drops to 3 mid-block
    set_key(31'd12345, 31'h4000_0001);
    drive_word(8'h96, 1'b0);
    drive_word(8'h69, 1'b0);
    drive_word(8'hC3, 1'b0);
    set_key(31'd7, 31'd5);
    drive_word(8'hE7, 1'b1);
    drive_word(8'h12, 1'b1);

    // last byte finishes more than six words; excess leaves with the next byte
    set_key(31'd3, '1);
    drive_word(8'hDE, 1'b0);
    drive_word(8'hAD, 1'b0);
    drive_word(8'hBE, 1'b0);
    drive_word(8'hEF, 1'b1);
    drive_word(8'h01, 1'b1);

    sent = 0;
    msg_left = 0;
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 7))
        0: e = '0;
        1: e = 31'd1;
        2: e = 31'($urandom_range(2, 17));
        3: e = 31'd65537;
        4: e = 31'($urandom_range(18, 65535));
        5, 6: e = 31'($urandom);
        default: e = '1;
      endcase
      case ($urandom_range(0, 7))
        0: n = 31'($urandom_range(0, 3));
        1: n = 31'($urandom_range(4, 64));
        2: n = 31'($urandom_range(65, 65535));
        3, 4: n = 31'($urandom);
        5: n = '1;
        6: begin
          // power of two and one above: block width boundaries
          sh = $urandom_range(1, 30);
          n = (31'd1 << sh) + 31'($urandom_range(0, 1));
        end
        default: n = 31'($urandom_range(2, 9));
      endcase
      set_key(e, n);
      phase_len = $urandom_range(15, 60);
      for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
        if (msg_left == 0) begin
          msg_left = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        end
        case ($urandom_range(0, 9))
          0: data = 8'h00;
          1: data = 8'hFF;
          default: data = 8'($urandom_range(0, 255));
        endcase
        last_flag = (msg_left == 1) || ($urandom_range(0, 19) == 0);
        msg_left = last_flag ? 0 : msg_left - 1;
        drive_word(data, last_flag);
        sent++;
      end
    end

    settle();
    if (fail_count == 0 && pending_words == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
